// File: src/tmc_pkg.sv
// ----------------------------------------------------------------------------
// tmc_pkg: shared types and constants for the thruster mixer
// Beat layouts, mode and register codes, sum width and the sign- and zero-extend helpers.
// ----------------------------------------------------------------------------
package tmc_pkg;

	localparam int NUM_MOTORS = 8;
	localparam int PULSE_W    = 16;
	localparam int CMD_W      = 16;
	// four signed 16-bit terms plus one unsigned 16-bit term fit in 19 bits
	localparam int SUM_W      = 19;
	localparam int CFG_IDX_W  = 2;

	localparam logic [1:0] KIND_MANUAL     = 2'd0;
	localparam logic [1:0] KIND_STABILIZED = 2'd1;
	localparam logic [1:0] KIND_FAILSAFE   = 2'd2;
	localparam logic [1:0] KIND_HOLD       = 2'd3;

	localparam logic [CFG_IDX_W-1:0] CFG_NEUTRAL = 2'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_UPPER   = 2'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_LOWER   = 2'd2;

	localparam logic [PULSE_W-1:0] NEUTRAL_RST = 16'd1500;
	localparam logic [PULSE_W-1:0] UPPER_RST   = 16'd2000;
	localparam logic [PULSE_W-1:0] LOWER_RST   = 16'd1000;

	typedef struct packed {
		logic [1:0]              kind;
		logic signed [CMD_W-1:0] surge;
		logic signed [CMD_W-1:0] sway;
		logic signed [CMD_W-1:0] heave;
		logic signed [CMD_W-1:0] stick_yaw;
		logic signed [CMD_W-1:0] roll_correction;
		logic signed [CMD_W-1:0] pitch_correction;
		logic signed [CMD_W-1:0] yaw_correction;
	} cmd_t;

	typedef struct packed {
		logic [PULSE_W-1:0] motor_1;
		logic [PULSE_W-1:0] motor_2;
		logic [PULSE_W-1:0] motor_3;
		logic [PULSE_W-1:0] motor_4;
		logic [PULSE_W-1:0] motor_5;
		logic [PULSE_W-1:0] motor_6;
		logic [PULSE_W-1:0] motor_7;
		logic [PULSE_W-1:0] motor_8;
	} mot_t;

	typedef logic [NUM_MOTORS-1:0][PULSE_W-1:0] motor_vec_t;
	typedef logic signed [SUM_W-1:0]            sum_t;

	typedef struct packed {
		logic [PULSE_W-1:0] neutral;
		logic [PULSE_W-1:0] upper;
		logic [PULSE_W-1:0] lower;
	} limits_t;

	function automatic sum_t sx(input logic signed [CMD_W-1:0] v);
		sx = {{(SUM_W-CMD_W){v[CMD_W-1]}}, v};
	endfunction

	function automatic sum_t ux(input logic [PULSE_W-1:0] v);
		ux = {{(SUM_W-PULSE_W){1'b0}}, v};
	endfunction

endpackage

// File: src/tmc_if.sv
// ----------------------------------------------------------------------------
// tmc_if: valid/ready channels of the thruster mixer
// Command channel in, motor channel out; one beat per valid & ready edge.
// ----------------------------------------------------------------------------
interface tmc_cmd_if;
	logic         valid;
	logic         ready;
	tmc_pkg::cmd_t data;

	modport source (output valid, output data, input ready);
	modport sink   (input valid, input data, output ready);
endinterface

interface tmc_mot_if;
	logic         valid;
	logic         ready;
	tmc_pkg::mot_t data;

	modport source (output valid, output data, input ready);
	modport sink   (input valid, input data, output ready);
endinterface

// File: src/tmc_clamp.sv
// ----------------------------------------------------------------------------
// tmc_clamp: limit one motor sum to the pulse window
// Upper test first, then lower, so upper wins if the limits cross and the sum exceeds upper.
// ----------------------------------------------------------------------------
module tmc_clamp (
	input  tmc_pkg::sum_t                 sum,
	input  logic [tmc_pkg::PULSE_W-1:0]   upper,
	input  logic [tmc_pkg::PULSE_W-1:0]   lower,
	output logic [tmc_pkg::PULSE_W-1:0]   pulse
);

	always_comb begin
		if (sum > tmc_pkg::ux(upper)) begin
			pulse = upper;
		end else if (sum < tmc_pkg::ux(lower)) begin
			pulse = lower;
		end else begin
			pulse = sum[tmc_pkg::PULSE_W-1:0];
		end
	end

endmodule

// File: src/tmc_mix.sv
// ----------------------------------------------------------------------------
// tmc_mix: motor mixing sums and clamps
// Eight signed sums plus neutral, each clamped to the limit window.
// ----------------------------------------------------------------------------
module tmc_mix (
	input  tmc_pkg::cmd_t      cmd,
	input  tmc_pkg::limits_t   lim,
	output tmc_pkg::motor_vec_t pulses
);

	tmc_pkg::sum_t x, y, z, yaw, cr, cp, cy, n;
	tmc_pkg::sum_t sums [tmc_pkg::NUM_MOTORS];
	logic          stab;

	assign stab = (cmd.kind == tmc_pkg::KIND_STABILIZED);

	assign x   = tmc_pkg::sx(cmd.surge);
	assign y   = tmc_pkg::sx(cmd.sway);
	assign z   = tmc_pkg::sx(cmd.heave);
	assign yaw = tmc_pkg::sx(cmd.stick_yaw);
	// corrections only count in stabilized mode
	assign cr  = stab ? tmc_pkg::sx(cmd.roll_correction)  : '0;
	assign cp  = stab ? tmc_pkg::sx(cmd.pitch_correction) : '0;
	assign cy  = stab ? tmc_pkg::sx(cmd.yaw_correction)   : '0;
	assign n   = tmc_pkg::ux(lim.neutral);

	always_comb begin
		sums[0] =  z + cr - cp + n;
		sums[1] =  z + cr + cp + n;
		sums[2] =  z - cr + cp + n;
		sums[3] =  z - cr - cp + n;
		sums[4] = -x - y - yaw + cy + n;
		sums[5] =  x - y + yaw - cy + n;
		sums[6] =  x + y - yaw + cy + n;
		sums[7] = -x + y + yaw - cy + n;
	end

	for (genvar i = 0; i < tmc_pkg::NUM_MOTORS; i++) begin : g_clamp
		tmc_clamp u_clamp (
			.sum   (sums[i]),
			.upper (lim.upper),
			.lower (lim.lower),
			.pulse (pulses[i])
		);
	end

endmodule

// File: src/thruster_mixer_clamp.sv
// ----------------------------------------------------------------------------
// thruster_mixer_clamp: eight-thruster mixer with limits and hold store
// Mixes stick and attitude commands into eight clamped motor pulse values.
// ----------------------------------------------------------------------------
//
//  channel | dir | handshake     | beat
//  --------+-----+---------------+-------------------------------------------
//  cmd     | in  | valid/ready   | kind, four stick and three correction words
//  motors  | out | valid/ready   | motor_1 .. motor_8 pulse values
//  cfg     | in  | cfg_we only   | cfg_index selects register, cfg_data value
//
//  Two register stages: the command register (_s1) and the motor register
//  (_s2), with the mix and clamp logic between them. A motor beat is valid
//  once its command has moved from _s1 into _s2, which a motors stall can
//  hold up; one beat per cycle sustained while motors stays ready.
//  Both stages advance together, so a stall on motors backs up into cmd
//  only once both registers are full.
//  Reset clears stage valids, restores register defaults and zeroes the
//  hold store. No clearing pass.
//
module thruster_mixer_clamp (
	input  logic                             clk,
	input  logic                             arst_n,
	tmc_cmd_if.sink                          cmd,
	tmc_mot_if.source                        motors,
	input  logic                             cfg_we,
	input  logic [tmc_pkg::CFG_IDX_W-1:0]    cfg_index,
	input  logic [tmc_pkg::PULSE_W-1:0]      cfg_data
);

	// configuration registers
	tmc_pkg::limits_t lim_q;

	// stage 1: captured command
	logic          v_s1;
	tmc_pkg::cmd_t cmd_s1;

	// stage 2: motor beat waiting on the output
	logic          v_s2;
	tmc_pkg::mot_t mot_s2;

	// last clamped motor values, returned by hold
	tmc_pkg::motor_vec_t held_q;

	tmc_pkg::motor_vec_t clamped;
	tmc_pkg::motor_vec_t result;
	logic                adv2, adv1, move, compute;

	// stage 2 frees up when empty or drained this cycle
	assign adv2    = !v_s2 || motors.ready;
	assign adv1    = !v_s1 || adv2;
	assign move    = v_s1 && adv2;
	assign compute = (cmd_s1.kind == tmc_pkg::KIND_MANUAL) ||
	                 (cmd_s1.kind == tmc_pkg::KIND_STABILIZED);

	assign cmd.ready    = adv1;
	assign motors.valid = v_s2;
	assign motors.data  = mot_s2;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			lim_q.neutral <= tmc_pkg::NEUTRAL_RST;
			lim_q.upper   <= tmc_pkg::UPPER_RST;
			lim_q.lower   <= tmc_pkg::LOWER_RST;
		end else if (cfg_we) begin
			case (cfg_index)
				tmc_pkg::CFG_NEUTRAL: lim_q.neutral <= cfg_data;
				tmc_pkg::CFG_UPPER:   lim_q.upper   <= cfg_data;
				tmc_pkg::CFG_LOWER:   lim_q.lower   <= cfg_data;
				default: ;  // unmapped index, dropped
			endcase
		end
	end

	tmc_mix u_mix (
		.cmd    (cmd_s1),
		.lim    (lim_q),
		.pulses (clamped)
	);

	// failsafe bypasses the clamp, hold replays the store
	always_comb begin
		case (cmd_s1.kind)
			tmc_pkg::KIND_FAILSAFE: result = {tmc_pkg::NUM_MOTORS{lim_q.neutral}};
			tmc_pkg::KIND_HOLD:     result = held_q;
			default:                result = clamped;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
		end else begin
			if (adv1) v_s1 <= cmd.valid;
			if (adv2) v_s2 <= v_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (adv1 && cmd.valid) cmd_s1 <= cmd.data;
		if (move) begin
			mot_s2.motor_1 <= result[0];
			mot_s2.motor_2 <= result[1];
			mot_s2.motor_3 <= result[2];
			mot_s2.motor_4 <= result[3];
			mot_s2.motor_5 <= result[4];
			mot_s2.motor_6 <= result[5];
			mot_s2.motor_7 <= result[6];
			mot_s2.motor_8 <= result[7];
		end
	end

	// store updates only on computed beats, in beat order
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			held_q <= '0;
		end else if (move && compute) begin
			held_q <= clamped;
		end
	end

`ifndef SYNTH
	// failsafe beat comes out as neutral, checked on motor_1 and motor_8
	a_failsafe_neutral: assert property (@(posedge clk) disable iff (!arst_n)
		move && cmd_s1.kind == tmc_pkg::KIND_FAILSAFE |=>
		mot_s2.motor_1 == lim_q.neutral && mot_s2.motor_8 == lim_q.neutral)
		else $error("failsafe beat not neutral");

	// failsafe and hold leave the store untouched
	a_store_kept: assert property (@(posedge clk) disable iff (!arst_n)
		move && !compute |=> $stable(held_q))
		else $error("hold store changed on non-computing beat");

	// a computed beat and the store agree, checked on motor_1 and motor_8
	a_store_matches: assert property (@(posedge clk) disable iff (!arst_n)
		move && compute |=>
		held_q[0] == mot_s2.motor_1 && held_q[7] == mot_s2.motor_8)
		else $error("hold store differs from computed beat");

	// both stages full and output stalled: no new command taken
	a_backpressure: assert property (@(posedge clk) disable iff (!arst_n)
		v_s1 && v_s2 && !motors.ready |-> !cmd.ready)
		else $error("command accepted into full pipeline");
`endif

endmodule

// File: tb/tb_top.sv
// ----------------------------------------------------------------------------
// tb_top: self-checking bench for thruster_mixer_clamp
// Drives command beats through a directed table and then random phases under
// several limit settings. Every motor beat is checked field by field against
// a typed-in result or an in-bench mixer/clamp model with its own hold store,
// under random idling on both channels and one long output stall.
// ----------------------------------------------------------------------------
module tb_top;

	// index 3 decodes to no register; writes there must be dropped
	localparam logic [tmc_pkg::CFG_IDX_W-1:0] CFG_SPARE = 2'd3;

	localparam int PHASES       = 8;
	localparam int PHASE_ITEMS  = 190;
	localparam int GAP_MAX      = 6;
	// long receiver hold-off, lands in phase 3, which has no idling
	localparam int STALL_AT     = 650;
	localparam int STALL_CYC    = 150;
	localparam int TAIL_CYC     = 8;
	localparam int LIMIT_CYC    = 200000;
	localparam int REPORT_LINES = 40;

	// directed row: command, whether the result is typed in, and that result
	typedef struct packed {
		tmc_pkg::cmd_t c;
		bit            typed;
		tmc_pkg::mot_t res;
	} dir_row_t;

	logic                          clk;
	logic                          arst_n;
	logic                          cfg_we;
	logic [tmc_pkg::CFG_IDX_W-1:0] cfg_index;
	logic [tmc_pkg::PULSE_W-1:0]   cfg_data;

	tmc_cmd_if cmd_ch ();
	tmc_mot_if mot_ch ();

	thruster_mixer_clamp i_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd       (cmd_ch),
		.motors    (mot_ch),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	// model copy of the limit registers and the hold store
	logic [tmc_pkg::PULSE_W-1:0] neutral_sh;
	logic [tmc_pkg::PULSE_W-1:0] upper_sh;
	logic [tmc_pkg::PULSE_W-1:0] lower_sh;
	logic [tmc_pkg::PULSE_W-1:0] held_pulse [tmc_pkg::NUM_MOTORS];

	tmc_pkg::mot_t pending_pulses [$];   // motor beats still owed by the DUT
	dir_row_t      dir_tab [$];

	int cyc;
	int n_err;
	int rx_beats;
	int kind_seen [4];
	int tx_gap_max;
	int rx_gap_max;
	int tx_gap;
	bit tx_live;                    // cmd valid left high for the next beat

	// ------------------------------------------------------------------
	// clock, cycle count, watchdog
	// ------------------------------------------------------------------
	initial clk = 1'b0;
	always begin
		#2 clk = 1'b1;
		#2 clk = 1'b0;
	end

	always @(posedge clk) begin
		cyc <= cyc + 1;
	end

	initial begin
		while (cyc < LIMIT_CYC) @(posedge clk);
		$display("timeout after %0d cycles, %0d beats still owed", cyc,
		         pending_pulses.size());
		$display("[thruster_mixer_clamp] ERROR");
		$finish;
	end

	// ------------------------------------------------------------------
	// mixer/clamp model: returns the beat a command should produce and
	// updates the hold store the same way the block does
	// ------------------------------------------------------------------
	function automatic tmc_pkg::mot_t mix_and_clamp(tmc_pkg::cmd_t c);
		int x, y, z, w, cr, cp, cy, nt, i;
		int s [tmc_pkg::NUM_MOTORS];
		logic [tmc_pkg::PULSE_W-1:0] v [tmc_pkg::NUM_MOTORS];
		x  = $signed(c.surge);
		y  = $signed(c.sway);
		z  = $signed(c.heave);
		w  = $signed(c.stick_yaw);
		cr = $signed(c.roll_correction);
		cp = $signed(c.pitch_correction);
		cy = $signed(c.yaw_correction);
		nt = int'(neutral_sh);
		case (c.kind)
			tmc_pkg::KIND_FAILSAFE: begin
				// neutral on every motor, no clamp, store untouched
				for (i = 0; i < tmc_pkg::NUM_MOTORS; i++) v[i] = neutral_sh;
			end
			tmc_pkg::KIND_HOLD: begin
				for (i = 0; i < tmc_pkg::NUM_MOTORS; i++) v[i] = held_pulse[i];
			end
			default: begin
				// manual ignores the attitude corrections
				if (c.kind == tmc_pkg::KIND_MANUAL) begin
					cr = 0;
					cp = 0;
					cy = 0;
				end
				s[0] = z + cr - cp + nt;
				s[1] = z + cr + cp + nt;
				s[2] = z - cr + cp + nt;
				s[3] = z - cr - cp + nt;
				s[4] = -x - y - w + cy + nt;
				s[5] =  x - y + w - cy + nt;
				s[6] =  x + y - w + cy + nt;
				s[7] = -x + y + w - cy + nt;
				// upper test first: with inverted limits it wins on big sums
				for (i = 0; i < tmc_pkg::NUM_MOTORS; i++) begin
					if (s[i] > int'(upper_sh)) v[i] = upper_sh;
					else if (s[i] < int'(lower_sh)) v[i] = lower_sh;
					else v[i] = 16'(s[i]);
					held_pulse[i] = v[i];
				end
			end
		endcase
		return {v[0], v[1], v[2], v[3], v[4], v[5], v[6], v[7]};
	endfunction

	function automatic tmc_pkg::cmd_t cmd_of(logic [1:0] k, int su, int sw, int hv, int sy,
	                                          int rc, int pc, int yc);
		tmc_pkg::cmd_t c;
		c.kind             = k;
		c.surge            = 16'(su);
		c.sway             = 16'(sw);
		c.heave            = 16'(hv);
		c.stick_yaw        = 16'(sy);
		c.roll_correction  = 16'(rc);
		c.pitch_correction = 16'(pc);
		c.yaw_correction   = 16'(yc);
		return c;
	endfunction

	function automatic tmc_pkg::mot_t pulses(int a, int b, int c, int d, int e, int f,
	                                          int g, int h);
		return {16'(a), 16'(b), 16'(c), 16'(d), 16'(e), 16'(f), 16'(g), 16'(h)};
	endfunction

	// command word: extremes, values near the limit window, or anything
	function automatic logic [tmc_pkg::CMD_W-1:0] draw_word();
		case ($urandom_range(0, 9))
			0:       return 16'h7FFF;
			1:       return 16'h8000;
			2, 3, 4, 5: return 16'(int'($urandom_range(0, 2400)) - 1200);
			default: return 16'($urandom);
		endcase
	endfunction

	function automatic tmc_pkg::cmd_t draw_cmd();
		tmc_pkg::cmd_t c;
		int            r;
		r = $urandom_range(0, 99);
		if (r < 35) c.kind = tmc_pkg::KIND_MANUAL;
		else if (r < 75) c.kind = tmc_pkg::KIND_STABILIZED;
		else if (r < 85) c.kind = tmc_pkg::KIND_FAILSAFE;
		else c.kind = tmc_pkg::KIND_HOLD;
		c.surge            = draw_word();
		c.sway             = draw_word();
		c.heave            = draw_word();
		c.stick_yaw        = draw_word();
		c.roll_correction  = draw_word();
		c.pitch_correction = draw_word();
		c.yaw_correction   = draw_word();
		return c;
	endfunction

	task automatic report(string msg);
		// print the first few, keep counting after that
		if (n_err < REPORT_LINES) $display("[cyc %0d] mismatch: %s", cyc, msg);
		n_err++;
	endtask

	// ------------------------------------------------------------------
	// command side
	// ------------------------------------------------------------------
	task automatic offer(tmc_pkg::cmd_t c, bit typed, tmc_pkg::mot_t typed_res);
		tmc_pkg::mot_t pred;
		repeat (tx_gap) @(posedge clk);
		cmd_ch.valid <= 1'b1;
		cmd_ch.data  <= c;
		do @(posedge clk); while (!cmd_ch.ready);
		// beat taken at this edge
		pred = mix_and_clamp(c);
		pending_pulses.push_back(typed ? typed_res : pred);
		kind_seen[c.kind]++;
		// next gap decided now, so valid is touched once per step
		tx_gap  = $urandom_range(0, tx_gap_max);
		tx_live = (tx_gap == 0);
		if (!tx_live) cmd_ch.valid <= 1'b0;
	endtask

	// wait out every owed beat, then the extra cycles asked for
	task automatic drain(int extra);
		if (tx_live) begin
			cmd_ch.valid <= 1'b0;
			tx_live = 1'b0;
		end
		while (pending_pulses.size() != 0) @(posedge clk);
		repeat (extra) @(posedge clk);
	endtask

	task automatic load_limits(logic [tmc_pkg::PULSE_W-1:0] n,
	                           logic [tmc_pkg::PULSE_W-1:0] u,
	                           logic [tmc_pkg::PULSE_W-1:0] l, bit poke_spare);
		cfg_we    <= 1'b1;
		cfg_index <= tmc_pkg::CFG_NEUTRAL;
		cfg_data  <= n;
		@(posedge clk);
		cfg_index <= tmc_pkg::CFG_UPPER;
		cfg_data  <= u;
		@(posedge clk);
		cfg_index <= tmc_pkg::CFG_LOWER;
		cfg_data  <= l;
		@(posedge clk);
		if (poke_spare) begin
			cfg_index <= CFG_SPARE;
			cfg_data  <= 16'hFFFF;
			@(posedge clk);
		end
		cfg_we     <= 1'b0;
		neutral_sh = n;
		upper_sh   = u;
		lower_sh   = l;
	endtask

	// ------------------------------------------------------------------
	// motor side: random ready, one long hold-off, compare each beat
	// ------------------------------------------------------------------
	task automatic check_beat(tmc_pkg::mot_t got);
		tmc_pkg::mot_t want;
		logic [tmc_pkg::NUM_MOTORS*tmc_pkg::PULSE_W-1:0] gb, wb;
		int i;
		int sh;
		if (pending_pulses.size() == 0) begin
			report($sformatf("motor beat %h with nothing owed", got));
		end else begin
			want = pending_pulses.pop_front();
			gb   = got;
			wb   = want;
			for (i = 0; i < tmc_pkg::NUM_MOTORS; i++) begin
				sh = (tmc_pkg::NUM_MOTORS - 1 - i) * tmc_pkg::PULSE_W;
				if (gb[sh +: tmc_pkg::PULSE_W] !== wb[sh +: tmc_pkg::PULSE_W])
					report($sformatf("beat %0d motor_%0d got %0d want %0d", rx_beats,
					       i + 1, gb[sh +: tmc_pkg::PULSE_W], wb[sh +: tmc_pkg::PULSE_W]));
			end
		end
	endtask

	initial begin
		int w;
		mot_ch.ready <= 1'b0;
		do @(posedge clk); while (!arst_n);
		forever begin
			// STALL_AT: hold ready low long enough to fill both stages
			w = (rx_beats == STALL_AT) ? STALL_CYC : $urandom_range(0, rx_gap_max);
			if (w > 0) begin
				mot_ch.ready <= 1'b0;
				repeat (w) @(posedge clk);
			end
			mot_ch.ready <= 1'b1;
			do @(posedge clk); while (!mot_ch.valid);
			check_beat(mot_ch.data);
			rx_beats++;
		end
	end

	// ------------------------------------------------------------------
	// main sequence
	// ------------------------------------------------------------------
	initial begin
		int ph, k;
		logic [tmc_pkg::PULSE_W-1:0] n, u, l;
		tmc_pkg::mot_t none;

		// every DUT input known from time zero
		arst_n       <= 1'b0;
		cfg_we       <= 1'b0;
		cfg_index    <= tmc_pkg::CFG_NEUTRAL;
		cfg_data     <= '0;
		cmd_ch.valid <= 1'b0;
		cmd_ch.data  <= '0;

		cyc        = 0;
		n_err      = 0;
		rx_beats   = 0;
		tx_gap     = 0;
		tx_live    = 1'b0;
		tx_gap_max = GAP_MAX;
		rx_gap_max = GAP_MAX;
		none       = '0;
		for (k = 0; k < 4; k++) kind_seen[k] = 0;
		neutral_sh = tmc_pkg::NEUTRAL_RST;
		upper_sh   = tmc_pkg::UPPER_RST;
		lower_sh   = tmc_pkg::LOWER_RST;
		for (k = 0; k < tmc_pkg::NUM_MOTORS; k++) held_pulse[k] = '0;

		// directed rows, all under the reset limits 1500 / 2000 / 1000
		// hold before any compute gives the cleared store
		dir_tab.push_back('{cmd_of(tmc_pkg::KIND_HOLD, 0, 0, 0, 0, 0, 0, 0), 1'b1,
		                    pulses(0, 0, 0, 0, 0, 0, 0, 0)});
		dir_tab.push_back('{cmd_of(tmc_pkg::KIND_FAILSAFE, 0, 0, 0, 0, 0, 0, 0), 1'b1,
		                    pulses(1500, 1500, 1500, 1500, 1500, 1500, 1500, 1500)});
		dir_tab.push_back('{cmd_of(tmc_pkg::KIND_MANUAL, 0, 0, 0, 0, 0, 0, 0), 1'b1,
		                    pulses(1500, 1500, 1500, 1500, 1500, 1500, 1500, 1500)});
		dir_tab.push_back('{cmd_of(tmc_pkg::KIND_MANUAL, 32767, 32767, 32767, 32767,
		                           32767, 32767, 32767), 1'b1,
		                    pulses(2000, 2000, 2000, 2000, 1000, 2000, 2000, 2000)});
		dir_tab.push_back('{cmd_of(tmc_pkg::KIND_MANUAL, -32768, -32768, -32768, -32768,
		                           -32768, -32768, -32768), 1'b1,
		                    pulses(1000, 1000, 1000, 1000, 2000, 1000, 1000, 1000)});
		dir_tab.push_back('{cmd_of(tmc_pkg::KIND_HOLD, 32767, 0, 32767, 0, 0, 0, 0), 1'b1,
		                    pulses(1000, 1000, 1000, 1000, 2000, 1000, 1000, 1000)});
		// failsafe must leave the store alone
		dir_tab.push_back('{cmd_of(tmc_pkg::KIND_FAILSAFE, 32767, 32767, 32767, 32767,
		                           32767, 32767, 32767), 1'b1,
		                    pulses(1500, 1500, 1500, 1500, 1500, 1500, 1500, 1500)});
		dir_tab.push_back('{cmd_of(tmc_pkg::KIND_HOLD, 0, 0, 0, 0, 0, 0, 0), 1'b1,
		                    pulses(1000, 1000, 1000, 1000, 2000, 1000, 1000, 1000)});
		// sums landing exactly on the limits, and one just past them
		dir_tab.push_back('{cmd_of(tmc_pkg::KIND_MANUAL, 0, 0, 500, 0, 0, 0, 0), 1'b1,
		                    pulses(2000, 2000, 2000, 2000, 1500, 1500, 1500, 1500)});
		dir_tab.push_back('{cmd_of(tmc_pkg::KIND_MANUAL, 0, 0, -500, 0, 0, 0, 0), 1'b1,
		                    pulses(1000, 1000, 1000, 1000, 1500, 1500, 1500, 1500)});
		dir_tab.push_back('{cmd_of(tmc_pkg::KIND_MANUAL, -501, 0, 501, 0, 0, 0, 0), 1'b0,
		                    none});
		dir_tab.push_back('{cmd_of(tmc_pkg::KIND_STABILIZED, 10, -5, 100, 7, 20, -30, 3),
		                    1'b0, none});
		dir_tab.push_back('{cmd_of(tmc_pkg::KIND_STABILIZED, 32767, 32767, 32767, 32767,
		                           32767, 32767, 32767), 1'b0, none});
		dir_tab.push_back('{cmd_of(tmc_pkg::KIND_STABILIZED, -32768, -32768, -32768,
		                           -32768, -32768, -32768, -32768), 1'b0, none});
		// manual with nonzero corrections: they must drop out
		dir_tab.push_back('{cmd_of(tmc_pkg::KIND_MANUAL, 40, 0, 50, 0, 300, -200, 100),
		                    1'b0, none});
		dir_tab.push_back('{cmd_of(tmc_pkg::KIND_STABILIZED, 0, 0, 0, 0, 700, 0, 0), 1'b0,
		                    none});
		dir_tab.push_back('{cmd_of(tmc_pkg::KIND_HOLD, 0, 0, 0, 0, 0, 0, 0), 1'b0, none});
		dir_tab.push_back('{cmd_of(tmc_pkg::KIND_STABILIZED, 32767, -32768, 32767, -32768,
		                           32767, -32768, 32767), 1'b0, none});
		dir_tab.push_back('{cmd_of(tmc_pkg::KIND_STABILIZED, 0, 0, 0, 0, -400, 450, -600),
		                    1'b0, none});
		dir_tab.push_back('{cmd_of(tmc_pkg::KIND_FAILSAFE, -1, -1, -1, -1, -1, -1, -1),
		                    1'b1,
		                    pulses(1500, 1500, 1500, 1500, 1500, 1500, 1500, 1500)});

		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (dir_tab[k]) offer(dir_tab[k].c, dir_tab[k].typed, dir_tab[k].res);
		drain(2);

		// random phases, each under its own limits and idle profile
		for (ph = 0; ph < PHASES; ph++) begin
			case (ph)
				0: begin n = tmc_pkg::NEUTRAL_RST; u = tmc_pkg::UPPER_RST;
				         l = tmc_pkg::LOWER_RST;
				         tx_gap_max = GAP_MAX; rx_gap_max = GAP_MAX; end
				// widest window, neutral at the floor
				1: begin n = 16'd0; u = 16'hFFFF; l = 16'd0;
				         tx_gap_max = 0; rx_gap_max = GAP_MAX; end
				// everything pinned at the top
				2: begin n = 16'hFFFF; u = 16'hFFFF; l = 16'hFFFF;
				         tx_gap_max = GAP_MAX; rx_gap_max = 0; end
				// inverted window, no idling; the long stall falls here
				3: begin n = 16'd2000; u = 16'd1000; l = 16'd3000;
				         tx_gap_max = 0; rx_gap_max = 0; end
				4: begin n = 16'd0; u = 16'd0; l = 16'd0;
				         tx_gap_max = GAP_MAX; rx_gap_max = GAP_MAX; end
				5: begin n = 16'($urandom); u = 16'($urandom); l = 16'($urandom);
				         tx_gap_max = 3; rx_gap_max = GAP_MAX; end
				6: begin n = 16'd32768; u = 16'd40000; l = 16'd20000;
				         tx_gap_max = GAP_MAX; rx_gap_max = 3; end
				default: begin n = 16'($urandom); u = 16'($urandom); l = 16'($urandom);
				         tx_gap_max = 0; rx_gap_max = 0; end
			endcase
			load_limits(n, u, l, ph == 5);
			for (k = 0; k < PHASE_ITEMS; k++) offer(draw_cmd(), 1'b0, none);
			drain(2);
		end

		drain(TAIL_CYC);

		$display("ran %0d commands: %0d manual, %0d stabilized, %0d failsafe, %0d hold",
		         kind_seen[0] + kind_seen[1] + kind_seen[2] + kind_seen[3],
		         kind_seen[0], kind_seen[1], kind_seen[2], kind_seen[3]);
		$display("%0d limit loads incl. inverted and pinned windows, %0d beats, %0d mismatches",
		         PHASES, rx_beats, n_err);
		if (n_err == 0) begin
			$display("[thruster_mixer_clamp] OK");
		end else begin
			$display("[thruster_mixer_clamp] ERROR");
		end
		$finish;
	end

endmodule

// File: files.f
src/tmc_pkg.sv
src/tmc_if.sv
src/tmc_clamp.sv
src/tmc_mix.sv
src/thruster_mixer_clamp.sv
tb/tb_top.sv
